>>> rtl/gedfs_pkg.sv
// shared types and constants for the graph edit and depth-first search block
package gedfs_pkg;

	localparam int CMD_W  = 3;
	localparam int NODE_W = 6;
	localparam int NCNT_W = 7;
	localparam int ECNT_W = 11;

	localparam logic [CMD_W-1:0] CMD_ADD_NODE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEL_EDGE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_NODE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH   = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD_NODE = 3'd0,
		OP_ADD_EDGE = 3'd1,
		OP_DEL_EDGE = 3'd2,
		OP_DEL_NODE = 3'd3,
		OP_SEARCH   = 3'd4,
		OP_NOP      = 3'd5
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic              a_ok;
		logic              b_ok;
	} task_t;

	typedef struct packed {
		logic [NODE_W-1:0] visit_node;
		logic              visit_valid;
		logic              last;
		logic [NCNT_W-1:0] node_count;
		logic [ECNT_W-1:0] edge_count;
	} result_t;

endpackage

>>> rtl/gedfs_fifo.sv
// small first-in first-out queue used between the front, the back and the result side
module gedfs_fifo #(
	parameter int W  = 8,
	parameter int AW = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int DEPTH = 1 << AW;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/gedfs_front.sv
// front end: accepts commands, decodes and range checks them, queues them for the back end
module gedfs_front import gedfs_pkg::*; #(
	parameter int NODES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	input  logic              task_rd,
	output task_t             task_head,
	output logic              task_empty
);

	task_t                   cls;
	logic [$bits(task_t)-1:0] head_bits;

	always_comb begin
		cls.a    = node_a;
		cls.b    = node_b;
		cls.a_ok = (32'(node_a) < NODES);
		cls.b_ok = (32'(node_b) < NODES);
		unique case (cmd)
			CMD_ADD_NODE: cls.op = OP_ADD_NODE;
			CMD_ADD_EDGE: cls.op = OP_ADD_EDGE;
			CMD_DEL_EDGE: cls.op = OP_DEL_EDGE;
			CMD_DEL_NODE: cls.op = OP_DEL_NODE;
			CMD_SEARCH:   cls.op = OP_SEARCH;
			default:      cls.op = OP_NOP;
		endcase
	end

	gedfs_fifo #(.W($bits(task_t)), .AW(2)) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (cls),
		.full  (full),
		.rd    (task_rd),
		.rdata (head_bits),
		.empty (task_empty)
	);

	assign task_head = task_t'(head_bits);

endmodule

>>> rtl/gedfs_back.sv
// back end: graph state, edit execution and the stack-based depth-first search
module gedfs_back import gedfs_pkg::*; #(
	parameter int NODES       = 64,
	parameter int STACK_DEPTH = 4096
) (
	input  logic    clk,
	input  logic    arst_n,
	input  task_t   task_head,
	input  logic    task_empty,
	output logic    task_rd,
	output logic    res_wr,
	output result_t res_data,
	input  logic    res_full
);

	localparam int IW  = $clog2(NODES);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_EXEC = 12'b0000_0000_0010,
		ST_ROWA = 12'b0000_0000_0100,
		ST_ROWB = 12'b0000_0000_1000,
		ST_DELN = 12'b0000_0001_0000,
		ST_DELW = 12'b0000_0010_0000,
		ST_ACK  = 12'b0000_0100_0000,
		ST_POP  = 12'b0000_1000_0000,
		ST_RD   = 12'b0001_0000_0000,
		ST_NBR  = 12'b0010_0000_0000,
		ST_PUSH = 12'b0100_0000_0000,
		ST_FIN  = 12'b1000_0000_0000
	} state_t;

	state_t             st_q;
	task_t              tk_q;
	logic [NODES-1:0]   adj_mem [NODES];
	logic [NODES-1:0]   adj_rd_s2;
	logic               rowv_s2;
	logic [NODES-1:0]   rv_q;
	logic [NODES-1:0]   pres_q;
	logic [NODES-1:0]   vis_q;
	logic [NODES-1:0]   mask_q;
	logic [NCNT_W-1:0]  ncnt_q;
	logic [ECNT_W-1:0]  ecnt_q;
	logic [SPW-1:0]     sp_q;
	logic [IW-1:0]      stk_mem [STACK_DEPTH];
	logic [IW-1:0]      rd_node_s2;
	logic [IW-1:0]      pend_q;
	logic [IW-1:0]      cur_q;
	logic               pend_v_q;

	logic [IW-1:0]      ai, bi, hi;
	logic [NODES-1:0]   row, abit, bbit, hbit;
	logic               pa, pb, ne, ab_edge, add_op, edge_op, rd_a, visit_go;
	logic               adj_we, adj_re;
	logic [IW-1:0]      adj_wa, adj_ra;
	logic [NODES-1:0]   adj_wd;
	logic               stk_we, stk_re;
	logic [SAW-1:0]     stk_wa, stk_ra;
	logic [IW-1:0]      stk_wd;
	logic [SPW-1:0]     sp_dec;

	assign ai       = tk_q.a[IW-1:0];
	assign bi       = tk_q.b[IW-1:0];
	assign pa       = pres_q[ai];
	assign pb       = pres_q[bi];
	assign ne       = (ai != bi);
	assign abit     = NODES'(1) << ai;
	assign bbit     = NODES'(1) << bi;
	assign hbit     = NODES'(1) << hi;
	assign row      = rowv_s2 ? adj_rd_s2 : '0;
	assign ab_edge  = row[bi];
	assign add_op   = (tk_q.op == OP_ADD_EDGE);
	assign edge_op  = add_op || (tk_q.op == OP_DEL_EDGE);
	assign rd_a     = (edge_op && tk_q.a_ok && tk_q.b_ok && ne) ||
		((tk_q.op == OP_DEL_NODE) && tk_q.a_ok);
	assign visit_go = (st_q == ST_RD) && !vis_q[rd_node_s2] && !(pend_v_q && res_full);
	assign sp_dec   = sp_q - 1'b1;
	assign task_rd  = (st_q == ST_IDLE) && !task_empty;

	always_comb begin
		hi = '0;
		for (int i = 0; i < NODES; i++) begin
			if (mask_q[i]) begin
				hi = IW'(i);
			end
		end
	end

	// one adjacency row read and one row write per cycle
	always_comb begin
		adj_we = 1'b0;
		adj_wa = ai;
		adj_wd = add_op ? (row | bbit) : (row & ~bbit);
		adj_re = 1'b0;
		adj_ra = bi;
		unique case (st_q)
			ST_EXEC: begin
				adj_re = rd_a;
				adj_ra = ai;
			end
			ST_ROWA: begin
				adj_we = 1'b1;
				if (tk_q.op == OP_DEL_NODE) begin
					adj_wd = '0;
				end else begin
					adj_re = 1'b1;
				end
			end
			ST_ROWB: begin
				adj_we = 1'b1;
				adj_wa = bi;
				adj_wd = add_op ? (row | abit) : (row & ~abit);
			end
			ST_DELN: begin
				adj_re = (mask_q != '0);
				adj_ra = hi;
			end
			ST_DELW: begin
				adj_we = 1'b1;
				adj_wa = cur_q;
				adj_wd = row & ~abit;
			end
			ST_RD: begin
				adj_re = visit_go;
				adj_ra = rd_node_s2;
			end
			default: begin
				adj_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_s2 <= adj_mem[adj_ra];
			rowv_s2   <= rv_q[adj_ra];
		end
	end

	always_comb begin
		stk_we = 1'b0;
		stk_wa = sp_q[SAW-1:0];
		stk_wd = hi;
		stk_re = 1'b0;
		stk_ra = sp_dec[SAW-1:0];
		if (st_q == ST_EXEC && tk_q.op == OP_SEARCH && tk_q.a_ok && pa) begin
			stk_we = 1'b1;
			stk_wa = '0;
			stk_wd = ai;
		end else if (st_q == ST_PUSH && mask_q != '0 && sp_q < SPW'(STACK_DEPTH)) begin
			stk_we = 1'b1;
		end
		if (st_q == ST_POP && sp_q != '0) begin
			stk_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			rd_node_s2 <= stk_mem[stk_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (task_rd) begin
			tk_q <= task_head;
		end
	end

	always_comb begin
		res_wr   = 1'b0;
		res_data.visit_node  = '0;
		res_data.visit_valid = 1'b0;
		res_data.last        = 1'b1;
		res_data.node_count  = ncnt_q;
		res_data.edge_count  = ecnt_q;
		priority case (1'b1)
			(st_q == ST_ACK): begin
				res_wr = !res_full;
			end
			(st_q == ST_FIN): begin
				res_wr = !res_full;
				res_data.visit_node  = NODE_W'(pend_q);
				res_data.visit_valid = pend_v_q;
			end
			(st_q == ST_RD): begin
				res_wr = pend_v_q && !vis_q[rd_node_s2] && !res_full;
				res_data.visit_node  = NODE_W'(pend_q);
				res_data.visit_valid = 1'b1;
				res_data.last        = 1'b0;
			end
			default: begin
				res_wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			rv_q     <= '0;
			pres_q   <= '0;
			vis_q    <= '0;
			mask_q   <= '0;
			ncnt_q   <= '0;
			ecnt_q   <= '0;
			sp_q     <= '0;
			pend_q   <= '0;
			cur_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (!task_empty) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (tk_q.op)
						OP_ADD_NODE: begin
							st_q <= ST_ACK;
							if (tk_q.a_ok) begin
								pres_q <= pres_q | abit;
								ncnt_q <= ncnt_q + NCNT_W'(!pa);
							end
						end
						OP_ADD_EDGE, OP_DEL_NODE: begin
							st_q <= rd_a ? ST_ROWA : ST_ACK;
						end
						OP_DEL_EDGE: begin
							st_q <= rd_a ? ST_ROWA : ST_ACK;
							if (!rd_a && tk_q.a_ok && tk_q.b_ok) begin
								pres_q <= pres_q | abit;
								ncnt_q <= ncnt_q + NCNT_W'(!pa);
							end
						end
						OP_SEARCH: begin
							vis_q    <= '0;
							pend_v_q <= 1'b0;
							pend_q   <= '0;
							if (tk_q.a_ok && pa) begin
								sp_q <= SPW'(1);
								st_q <= ST_POP;
							end else begin
								sp_q <= '0;
								st_q <= ST_ACK;
							end
						end
						default: begin
							st_q <= ST_ACK;
						end
					endcase
				end
				ST_ROWA: begin
					if (tk_q.op == OP_DEL_NODE) begin
						mask_q <= row;
						st_q   <= ST_DELN;
					end else begin
						pres_q <= pres_q | abit | bbit;
						ncnt_q <= ncnt_q + NCNT_W'(!pa) + NCNT_W'(!pb);
						ecnt_q <= add_op ? ecnt_q + ECNT_W'(!ab_edge)
							: ecnt_q - ECNT_W'(ab_edge);
						st_q   <= ST_ROWB;
					end
				end
				ST_ROWB: begin
					st_q <= ST_ACK;
				end
				ST_DELN: begin
					if (mask_q == '0) begin
						pres_q <= pres_q & ~abit;
						ncnt_q <= ncnt_q - NCNT_W'(pa);
						st_q   <= ST_ACK;
					end else begin
						mask_q <= mask_q & ~hbit;
						cur_q  <= hi;
						st_q   <= ST_DELW;
					end
				end
				ST_DELW: begin
					ecnt_q <= ecnt_q - 1'b1;
					st_q   <= ST_DELN;
				end
				ST_ACK: begin
					if (!res_full) begin
						st_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						st_q <= ST_FIN;
					end else begin
						sp_q <= sp_dec;
						st_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (vis_q[rd_node_s2]) begin
						st_q <= ST_POP;
					end else if (!(pend_v_q && res_full)) begin
						vis_q    <= vis_q | (NODES'(1) << rd_node_s2);
						pend_q   <= rd_node_s2;
						pend_v_q <= 1'b1;
						st_q     <= ST_NBR;
					end
				end
				ST_NBR: begin
					mask_q <= row & ~vis_q;
					st_q   <= ST_PUSH;
				end
				ST_PUSH: begin
					if (mask_q == '0) begin
						st_q <= ST_POP;
					end else begin
						mask_q <= mask_q & ~hbit;
						if (sp_q < SPW'(STACK_DEPTH)) begin
							sp_q <= sp_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (!res_full) begin
						pend_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (adj_we) begin
				rv_q <= rv_q | (NODES'(1) << adj_wa);
			end
		end
	end

endmodule

>>> rtl/graph_edit_and_dfs_order.sv
// top level of the graph edit and depth-first search block
// usage:
//   input channel: cmd, node_a, node_b; an item is taken when push is high and
//   full is low. commands wait in a four-entry queue ahead of the executor.
//   result channel: visit_node, visit_valid, last, node_count, edge_count are
//   valid while empty is low; an item leaves when pop is high.
//   every edit gives one item with last set; a search gives one item per
//   visited node in depth-first order, last set on the final one, or a single
//   item with visit_valid low when the start node is absent.
// execution:
//   one command runs at a time. a node add or idle code is decoded and then
//   acknowledged; an edge add or delete reads and rewrites the rows of both
//   nodes; a node delete clears its own row, then its bit in each neighbour's row.
//   a search pops the stack, reads the row of each newly visited node and
//   pushes its unvisited neighbours, with one adjacency row read per visit and
//   at most one stack access per cycle, then writes the final item.
// reset: arst_n clears the graph, the counts and both queues at once.
// stall: when the result queue fills, the executor waits and the command
//   queue keeps filling until full rises.
module graph_edit_and_dfs_order import gedfs_pkg::*; #(
	parameter int NODES       = 64,
	parameter int STACK_DEPTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	output logic              empty,
	input  logic              pop,
	output logic [NODE_W-1:0] visit_node,
	output logic              visit_valid,
	output logic              last,
	output logic [NCNT_W-1:0] node_count,
	output logic [ECNT_W-1:0] edge_count
);

	task_t                      task_head;
	logic                       task_empty, task_rd;
	logic                       res_wr, res_full;
	result_t                    res_data, res_head;
	logic [$bits(result_t)-1:0] res_bits;

	gedfs_front #(.NODES(NODES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.node_a    (node_a),
		.node_b    (node_b),
		.task_rd   (task_rd),
		.task_head (task_head),
		.task_empty(task_empty)
	);

	gedfs_back #(.NODES(NODES), .STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_head (task_head),
		.task_empty(task_empty),
		.task_rd   (task_rd),
		.res_wr    (res_wr),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	gedfs_fifo #(.W($bits(result_t)), .AW(2)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_wr),
		.wdata (res_data),
		.full  (res_full),
		.rd    (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign res_head    = result_t'(res_bits);
	assign visit_node  = res_head.visit_node;
	assign visit_valid = res_head.visit_valid;
	assign last        = res_head.last;
	assign node_count  = res_head.node_count;
	assign edge_count  = res_head.edge_count;

endmodule
